>>> rtl/core/signed_time_divide_by_ns_unit_macros.svh
// Assertion macros for the divider; clk_i and rst_ni must be in scope.
`ifndef SIGNED_TIME_DIVIDE_BY_NS_UNIT_MACROS_SVH
`define SIGNED_TIME_DIVIDE_BY_NS_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SDIVNS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SDIVNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sdivns_pkg.sv
package sdivns_pkg;

  localparam int unsigned NumBits    = 64;
  localparam int unsigned DenBits    = 63;
  localparam int unsigned NarrowBits = 32;
  localparam int unsigned CntBits    = 6;
  localparam int unsigned PcBits     = 3;

  typedef logic [PcBits-1:0] pc_t;

  localparam pc_t PcWait = 3'd0;
  localparam pc_t PcChkz = 3'd1;
  localparam pc_t PcNorm = 3'd2;
  localparam pc_t PcInit = 3'd3;
  localparam pc_t PcStep = 3'd4;
  localparam pc_t PcSign = 3'd5;
  localparam pc_t PcZero = 3'd6;
  localparam pc_t PcEmit = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_NORM,
    OP_INIT,
    OP_STEP,
    OP_SIGN,
    OP_ZERO
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IN_IDLE,
    COND_DEN_ZERO,
    COND_DEN_WIDE,
    COND_CNT_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   target;
    logic  accept;
    logic  emit;
  } uword_t;

  typedef struct packed {
    logic den_zero;
    logic den_wide;
    logic cnt_more;
  } status_t;

endpackage

>>> rtl/core/sdivns_ucode_rom.sv
module sdivns_ucode_rom
  import sdivns_pkg::*;
(
  input  pc_t    pc_i,
  output uword_t word_o
);

  always_comb begin
    unique case (pc_i)
      PcWait: word_o = '{op: OP_LOAD, cond: COND_IN_IDLE,  target: PcWait, accept: 1'b1,
                         emit: 1'b0};
      PcChkz: word_o = '{op: OP_NOP,  cond: COND_DEN_ZERO, target: PcZero, accept: 1'b0,
                         emit: 1'b0};
      PcNorm: word_o = '{op: OP_NORM, cond: COND_DEN_WIDE, target: PcNorm, accept: 1'b0,
                         emit: 1'b0};
      PcInit: word_o = '{op: OP_INIT, cond: COND_NEVER,    target: PcWait, accept: 1'b0,
                         emit: 1'b0};
      PcStep: word_o = '{op: OP_STEP, cond: COND_CNT_MORE, target: PcStep, accept: 1'b0,
                         emit: 1'b0};
      PcSign: word_o = '{op: OP_SIGN, cond: COND_ALWAYS,   target: PcEmit, accept: 1'b0,
                         emit: 1'b0};
      PcZero: word_o = '{op: OP_ZERO, cond: COND_NEVER,    target: PcWait, accept: 1'b0,
                         emit: 1'b0};
      PcEmit: word_o = '{op: OP_NOP,  cond: COND_OUT_BUSY, target: PcEmit, accept: 1'b0,
                         emit: 1'b1};
      default: word_o = '{op: OP_NOP, cond: COND_ALWAYS,   target: PcWait, accept: 1'b0,
                          emit: 1'b0};
    endcase
  end

endmodule

>>> rtl/core/sdivns_datapath.sv
module sdivns_datapath
  import sdivns_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  op_e                 op_i,
  input  logic [NumBits-1:0]  dividend_i,
  input  logic [DenBits-1:0]  divisor_i,
  output status_t             status_o,
  output logic [NumBits-1:0]  quotient_o,
  output logic                error_o
);

  logic [NumBits-1:0]    mag_q, mag_d;
  logic [DenBits-1:0]    den_q, den_d;
  logic [NarrowBits-1:0] rem_q, rem_d;
  logic [CntBits-1:0]    cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic                  err_q, err_d;

  logic [NarrowBits:0]   rem_sh;
  logic [NarrowBits:0]   den_ext;
  logic [NarrowBits:0]   diff;
  logic                  fits;
  logic                  den_wide;

  assign den_wide = |den_q[DenBits-1:NarrowBits];
  assign rem_sh   = {rem_q, mag_q[NumBits-1]};
  assign den_ext  = {1'b0, den_q[NarrowBits-1:0]};
  assign diff     = rem_sh - den_ext;
  assign fits     = rem_sh >= den_ext;

  always_comb begin
    mag_d = mag_q;
    den_d = den_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    err_d = err_q;
    unique case (op_i)
      OP_LOAD: begin
        neg_d = dividend_i[NumBits-1];
        mag_d = dividend_i[NumBits-1] ? (NumBits'(0) - dividend_i) : dividend_i;
        den_d = divisor_i;
        err_d = 1'b0;
      end
      OP_NORM: begin
        if (den_wide) begin
          den_d = den_q >> 1;
          mag_d = mag_q >> 1;
        end
      end
      OP_INIT: begin
        rem_d = '0;
        cnt_d = '0;
      end
      OP_STEP: begin
        rem_d = fits ? diff[NarrowBits-1:0] : rem_sh[NarrowBits-1:0];
        mag_d = {mag_q[NumBits-2:0], fits};
        cnt_d = cnt_q + CntBits'(1);
      end
      OP_SIGN: begin
        if (neg_q) begin
          mag_d = NumBits'(0) - mag_q;
        end
      end
      OP_ZERO: begin
        mag_d = '0;
        err_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    err_q <= err_d;
  end

  assign status_o.den_zero = ~|den_q;
  assign status_o.den_wide = den_wide;
  assign status_o.cnt_more = cnt_q != {CntBits{1'b1}};
  assign quotient_o        = mag_q;
  assign error_o           = err_q;

endmodule

>>> rtl/core/signed_time_divide_by_ns_unit.sv
// The divisor is shifted right, with the dividend magnitude, until it fits in 32 bits;
// then the divide runs 64 radix-2 steps. A zero divisor gives a zero result with the
// divide error flag set.
// Items are taken one at a time; the next input is taken while a result waits
// in the output register.
// Reset: asynchronous, active low; the step counter returns to the wait step and
// the output register empties.
`include "signed_time_divide_by_ns_unit_macros.svh"

module signed_time_divide_by_ns_unit
  import sdivns_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // dividend[63:0], divisor[126:64], zero pad[127]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // quotient[63:0]
  output logic         m_axis_tuser    // divide_error[0]
);

  pc_t     pc_q, pc_d;
  uword_t  word;
  status_t status;
  op_e     dp_op;
  logic    in_xfer;
  logic    out_busy;
  logic    out_load;
  logic    jump;

  logic [NumBits-1:0] quotient;
  logic               div_err;
  logic [NumBits-1:0] out_data_q;
  logic               out_err_q;
  logic               out_valid_q, out_valid_d;

  sdivns_ucode_rom u_rom (
    .pc_i   (pc_q),
    .word_o (word)
  );

  assign s_axis_tready = word.accept;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_busy      = out_valid_q && !m_axis_tready;
  assign out_load      = word.emit && !out_busy;
  assign dp_op         = (word.op == OP_LOAD && !in_xfer) ? OP_NOP : word.op;

  sdivns_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (dp_op),
    .dividend_i (s_axis_tdata[63:0]),
    .divisor_i  (s_axis_tdata[126:64]),
    .status_o   (status),
    .quotient_o (quotient),
    .error_o    (div_err)
  );

  always_comb begin
    unique case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_IN_IDLE:  jump = !s_axis_tvalid;
      COND_DEN_ZERO: jump = status.den_zero;
      COND_DEN_WIDE: jump = status.den_wide;
      COND_CNT_MORE: jump = status.cnt_more;
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b0;
    endcase
    pc_d = jump ? word.target : pc_q + PcBits'(1);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PcWait;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= quotient;
      out_err_q  <= div_err;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  `SDIVNS_ASSERT_NEXT(a_xfer_to_chkz, in_xfer, pc_q == PcChkz,
                      "input transfer did not advance to the zero check")
  `SDIVNS_ASSERT_NEXT(a_err_zero, out_load && div_err,
                      m_axis_tvalid && m_axis_tuser && (m_axis_tdata == '0),
                      "divide error result is not zero")
  `SDIVNS_ASSERT_NEXT(a_norm_exit, (pc_q == PcNorm) && !status.den_wide,
                      pc_q == PcInit, "normalization did not exit on narrow divisor")
  `SDIVNS_ASSERT_NOW(a_emit_free, out_load, !out_busy,
                     "result loaded over a pending transfer")

endmodule

>>> bench/signed_time_divide_by_ns_unit_test.sv
module signed_time_divide_by_ns_unit_test;
  import sdivns_pkg::*;

  typedef struct {
    logic [NumBits-1:0] dividend;
    logic [DenBits-1:0] divisor;
    bit                 drain;
  } divns_req_t;

  typedef struct {
    logic [NumBits-1:0] quotient;
    logic               divide_error;
  } divns_quot_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [127:0]  s_axis_tdata = '0;   // dividend[63:0], divisor[126:64], zero pad[127]
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [63:0]   m_axis_tdata;        // quotient[63:0]
  logic          m_axis_tuser;        // divide_error[0]

  divns_req_t    pending_q[$];
  divns_quot_t   quot_q[$];
  divns_req_t    cur_req;
  int            sent_cnt = 0;
  int            rcv_done = 0;
  int            total_items = 0;
  int            fail_cnt = 0;
  int            send_wait = 0;
  int            recv_wait = 0;

  signed_time_divide_by_ns_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic divns_quot_t divns_predict(logic [NumBits-1:0] num,
                                                logic [DenBits-1:0] den_in);
    divns_quot_t        r;
    logic [NumBits-1:0] den;
    logic [NumBits-1:0] mag;
    logic [NumBits-1:0] q;
    int                 sh;
    r.quotient = '0;
    r.divide_error = 1'b0;
    den = {1'b0, den_in};
    if (den == '0) begin
      r.divide_error = 1'b1;
      return r;
    end
    mag = num[NumBits-1] ? (64'd0 - num) : num;
    sh = 0;
    while (den[NumBits-1:NarrowBits] != '0) begin
      den = den >> 1;
      sh++;
    end
    mag = mag >> sh;
    q = mag / den;
    r.quotient = num[NumBits-1] ? (64'd0 - q) : q;
    return r;
  endfunction

  function automatic int draw_gap(int n);
    if (n % 128 >= 96) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DenBits-1:0] rand_divisor();
    logic [63:0] v;
    int          len;
    v = rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DenBits'($urandom_range(1, 16));
      2: return {DenBits{1'b1}};
      3, 4: begin
        v[63:32] = '0;
        if (v == '0) v = 64'd1;
        return v[DenBits-1:0];
      end
      5, 6: begin
        len = $urandom_range(33, 63);
        v = v & ((64'd1 << len) - 1);
        v[len-1] = 1'b1;
        return v[DenBits-1:0];
      end
      default: return v[DenBits-1:0];
    endcase
  endfunction

  function automatic logic [NumBits-1:0] rand_dividend();
    logic [63:0] v;
    v = rand64();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7FFF_FFFF_FFFF_FFFF;
      2: return 64'($signed($urandom_range(0, 2000)) - 1000);
      3: return {{32{v[63]}}, v[31:0]};
      default: return v;
    endcase
  endfunction

  task automatic add_req(logic [NumBits-1:0] num, logic [DenBits-1:0] den, bit drain);
    divns_req_t req;
    req.dividend = num;
    req.divisor = den;
    req.drain = drain;
    pending_q.push_back(req);
    total_items++;
  endtask

  always @(posedge clk_i) begin : drive_proc
    divns_req_t req;
    bit         fire;
    fire = s_axis_tvalid && s_axis_tready;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_wait <= draw_gap(0);
    end else begin
      if (fire) begin
        quot_q.push_back(divns_predict(cur_req.dividend, cur_req.divisor));
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_axis_tvalid || fire) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0 &&
                     !(pending_q[0].drain && (sent_cnt + int'(fire)) != rcv_done)) begin
          req = pending_q.pop_front();
          cur_req <= req;
          s_axis_tdata <= {1'b0, req.divisor, req.dividend};
          s_axis_tvalid <= 1'b1;
          send_wait <= draw_gap(sent_cnt + 1);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    divns_quot_t exp_r;
    int          w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait <= draw_gap(0);
    end else begin
      w = recv_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        if (quot_q.size() == 0) begin
          $error("result transfer with no expected quotient: quotient %0d, divide_error %0b",
                 $signed(m_axis_tdata), m_axis_tuser);
          fail_cnt++;
        end else begin
          exp_r = quot_q.pop_front();
          if (m_axis_tdata !== exp_r.quotient) begin
            $error("quotient: expected %0d, got %0d",
                   $signed(exp_r.quotient), $signed(m_axis_tdata));
            fail_cnt++;
          end
          if (m_axis_tuser !== exp_r.divide_error) begin
            $error("divide_error: expected %0b, got %0b", exp_r.divide_error, m_axis_tuser);
            fail_cnt++;
          end
        end
        rcv_done <= rcv_done + 1;
        w = draw_gap(rcv_done + 1);
      end
      if (w == 0) begin
        m_axis_tready <= 1'b1;
        recv_wait <= 0;
      end else begin
        m_axis_tready <= 1'b0;
        recv_wait <= w - 1;
      end
    end
  end

  initial begin
    add_req(64'd100, 63'd0, 1'b0);
    add_req(64'h8000_0000_0000_0000, 63'd0, 1'b0);
    add_req(64'h8000_0000_0000_0000, 63'd1, 1'b0);
    add_req(64'h8000_0000_0000_0000, 63'd2, 1'b0);
    add_req(64'h8000_0000_0000_0000, {DenBits{1'b1}}, 1'b0);
    add_req(64'h7FFF_FFFF_FFFF_FFFF, 63'd1, 1'b0);
    add_req(64'h7FFF_FFFF_FFFF_FFFF, {DenBits{1'b1}}, 1'b0);
    add_req(64'h7FFF_FFFF_FFFF_FFFF, 63'hFFFF_FFFF, 1'b0);
    add_req(64'h7FFF_FFFF_FFFF_FFFF, 63'h1_0000_0000, 1'b0);
    add_req(64'h7FFF_FFFF_FFFF_FFFF, 63'h1_0000_0001, 1'b0);
    add_req(-64'sd1, 63'd1, 1'b0);
    add_req(64'd1, 63'd1, 1'b0);
    add_req(64'd0, 63'd5, 1'b0);
    add_req(-64'sd7, 63'd2, 1'b0);
    add_req(64'd7, 63'd2, 1'b0);
    add_req(-64'sd1_000_000_007, 63'd1000, 1'b0);
    add_req(64'd3, 63'h4000_0000_0000_0000, 1'b1);
    add_req(64'h8000_0000_0000_0000, 63'h4000_0000_0000_0000, 1'b0);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, {DenBits{1'b1}}, 1'b0);
    add_req(64'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
    add_req(64'hAAAA_AAAA_AAAA_AAAA, 63'h5555_5555, 1'b0);
    for (int i = 0; i < 900; i++) begin
      add_req(rand_dividend(), rand_divisor(), (i % 300) == 150);
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt != total_items || rcv_done != total_items) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
    if (quot_q.size() != 0) begin
      $error("%0d expected quotients never arrived", quot_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("signed_time_divide_by_ns_unit_test OK");
    end else begin
      $display("signed_time_divide_by_ns_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #1200000;
    $display("signed_time_divide_by_ns_unit_test NOT OK");
    $finish;
  end

endmodule
